[hw/rtl/lzss_window_decoder_defines.svh]
// Assertion macros used by the decoder datapath.
`ifndef LZSS_WINDOW_DECODER_DEFINES_SVH
`define LZSS_WINDOW_DECODER_DEFINES_SVH

// Condition must never be seen at a clock edge outside reset.
`define LZSS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// Same-cycle implication.
`define LZSS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LZSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lzss_pkg.sv]
// Shared constants and controller/datapath types for the LZSS decoder.
package lzss_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int MATCH_BIAS   = 18;
  localparam int MIN_MATCH    = 3;

  localparam logic [3:0] FLAG_TOKENS = 4'd8;
  localparam logic [2:0] HDR_BYTES   = 3'd4;
  localparam logic [2:0] HDR_LAST    = 3'd3;

  // token phase codes
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_MATCH = 2'd2;

  typedef struct packed {
    logic       clear;      // start of stream: drop count and length
    logic       hdr_we;     // store one length byte
    logic [1:0] hdr_idx;
    logic       lit_load;   // literal into emit stage
    logic       off_load;   // first match byte
    logic       match_load; // second match byte
    logic       grp_end;    // this token closes its flag group
    logic       setup;      // resolve match source
    logic       copy_en;    // issue window reads
    logic [7:0] data;
  } dp_cmd_t;

  typedef struct packed {
    logic e_empty;      // nothing waiting in the emit stage
    logic copy_last;    // final window read issued this cycle
    logic len_low_zero; // length bytes 0..2 all zero
    logic stream_end;   // final byte of the stream handed to output
  } dp_stat_t;

endpackage

[hw/rtl/lzss_in_if.sv]
// Compressed byte channel.
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

[hw/rtl/lzss_out_if.sv]
// Decompressed byte channel.
interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

[hw/rtl/lzss_window_decoder.sv]
// LZSS decoder with a 4 KiB ring history: top level.
// Usage:
//  - in_link carries the compressed stream one byte per transaction. Raise
//    stream_start with the first of the four little-endian length bytes.
//  - Each flag byte then covers eight tokens, LSB first: set = literal byte,
//    clear = two-byte match (12-bit position + 18, length low nibble + 3).
//  - out_link gives one decompressed byte per transaction; run_last marks
//    the last byte caused by an input byte, stream_done the stream's end.
//  - Header and flag bytes give no output. A literal passes through the
//    emit stage, then the output register. A match steps through accept,
//    source set-up, one window read per byte, then the emit stage; the
//    window RAM has a single read port.
//  - The block takes one input byte at a time and waits until any match
//    copy is over and the emit stage is empty before the next transaction.
//  - Reset (rst, synchronous) leaves the decoder idle; bytes are ignored
//    until one arrives with stream_start. No clearing pass: reads of window
//    slots not written in the current stream return zero.
//  - If out_link stalls, the output register and emit stage hold and the
//    window reads pause; nothing is dropped.
module lzss_window_decoder (
  input  logic        clk,
  input  logic        rst,
  lzss_in_if.sink     in_link,
  lzss_out_if.source  out_link
);
  import lzss_pkg::*;

  dp_cmd_t  cmd;   // controller to datapath
  dp_stat_t stat;  // datapath to controller

  // Token parsing and match sequencing.
  lzss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_link (in_link),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Counters, window RAM, emit stage and output register.
  lzss_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .out_link (out_link)
  );
endmodule

[hw/rtl/lzss_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hw/rtl/lzss_datapath.sv]
// Decoder datapath: counters, match source resolution, window, emit stage, output register.
`include "lzss_window_decoder_defines.svh"
module lzss_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lzss_pkg::dp_cmd_t cmd,
  output lzss_pkg::dp_stat_t stat,
  lzss_out_if.source        out_link
);
  import lzss_pkg::*;

  logic [31:0] count;
  logic [31:0] length;
  logic [31:0] length_next;
  logic [7:0]  off_low;
  logic [3:0]  hi_nib;
  logic [4:0]  cnt;
  logic        grp_end_m;
  logic [WIN_AW-1:0] rd_addr;
  logic signed [13:0] r;    // write position minus read position
  logic signed [13:0] s;    // read position while still negative
  logic [31:0] q;           // write position seen by the read side

  // emit stage
  logic       e_valid;
  logic       e_zero;
  logic       e_hold_sel;
  logic [7:0] e_hold;
  logic       e_last;
  logic       e_grp_end;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_done;

  logic        advance;
  logic        e_move;
  logic        e_load_ok;
  logic        issue;
  logic        bypass;
  logic        byte_ok;
  logic [7:0]  ram_rdata;
  logic [7:0]  e_byte;
  logic [31:0] count_inc;
  logic        done_now;
  logic [12:0] base;
  logic [32:0] diff;
  logic        base_le_p;
  logic [12:0] span;
  logic signed [13:0] r_setup;
  logic signed [13:0] s_setup;

  assign advance   = !out_valid || out_link.ready;
  assign e_move    = e_valid && advance;
  assign e_load_ok = !e_valid || advance;
  assign issue     = cmd.copy_en && (cnt != 5'd0) && e_load_ok;
  assign bypass    = e_move && (rd_addr == count[WIN_AW-1:0]);
  assign byte_ok   = !s[13] && (r > 14'sd0);

  assign e_byte    = e_zero ? 8'd0 : (e_hold_sel ? e_hold : ram_rdata);
  assign count_inc = (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
  assign done_now  = e_grp_end && e_last && (count_inc >= length);

  // Source of a match: window position plus bias, folded to lie behind the write point.
  assign base      = 13'({hi_nib, off_low}) + 13'(MATCH_BIAS);
  assign diff      = {1'b0, count} - {20'd0, base};
  assign base_le_p = !diff[32];
  assign span      = ((diff[WIN_AW-1:0] == '0) && (diff[31:0] != 32'd0)) ?
                     13'(WINDOW_DEPTH) : {1'b0, diff[WIN_AW-1:0]};

  always_comb begin
    if (base_le_p) begin
      r_setup = signed'({1'b0, span});
      s_setup = 14'sd0;
    end else begin
      r_setup = signed'(diff[13:0] + 14'(WINDOW_DEPTH));
      s_setup = signed'({1'b0, base} - 14'(WINDOW_DEPTH));
    end
  end

  always_comb begin
    length_next = cmd.clear ? 32'd0 : length;
    if (cmd.hdr_we) begin
      length_next[{cmd.hdr_idx, 3'b000} +: 8] = cmd.data;
    end
  end

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (e_move),
    .waddr (count[WIN_AW-1:0]),
    .wdata (e_byte),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 32'd0;
      length    <= 32'd0;
      cnt       <= 5'd0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      length <= length_next;
      if (cmd.clear) begin
        count <= 32'd0;
      end else if (e_move) begin
        count <= count_inc;
      end
      if (cmd.match_load) begin
        cnt <= 5'(cmd.data[3:0]) + 5'(MIN_MATCH);
      end else if (issue) begin
        cnt <= cnt - 5'd1;
      end
      if (e_load_ok) begin
        e_valid <= issue || cmd.lit_load;
      end
      if (advance) begin
        out_valid <= e_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.off_load) begin
      off_low <= cmd.data;
    end
    if (cmd.match_load) begin
      hi_nib    <= cmd.data[7:4];
      grp_end_m <= cmd.grp_end;
    end
    if (cmd.setup) begin
      rd_addr <= base[WIN_AW-1:0];
      q       <= count;
      r       <= r_setup;
      s       <= s_setup;
    end else if (issue) begin
      rd_addr <= rd_addr + WIN_AW'(1);
      q       <= (q == 32'hFFFF_FFFF) ? q : q + 32'd1;
      r       <= (q == 32'hFFFF_FFFF) ? r - 14'sd1 : r;
      s       <= s[13] ? s + 14'sd1 : s;
    end
    if (issue) begin
      e_zero     <= !byte_ok;
      e_hold_sel <= bypass;
      e_hold     <= e_byte;
      e_last     <= (cnt == 5'd1);
      e_grp_end  <= grp_end_m;
    end else if (cmd.lit_load) begin
      e_zero     <= 1'b0;
      e_hold_sel <= 1'b1;
      e_hold     <= cmd.data;
      e_last     <= 1'b1;
      e_grp_end  <= cmd.grp_end;
    end
    if (e_move) begin
      out_byte <= e_byte;
      out_last <= e_last;
      out_done <= done_now;
    end
  end

  assign stat.e_empty      = !e_valid;
  assign stat.copy_last    = issue && (cnt == 5'd1);
  assign stat.len_low_zero = (length[23:0] == 24'd0);
  assign stat.stream_end   = e_move && done_now;

  assign out_link.valid       = out_valid;
  assign out_link.out_byte    = out_byte;
  assign out_link.run_last    = out_last;
  assign out_link.stream_done = out_done;

  `LZSS_ASSERT_IMPLY(a_lit_into_empty, cmd.lit_load, !e_valid, "literal loaded over busy stage")
  `LZSS_ASSERT_IMPLY(a_setup_has_len, cmd.setup, cnt != 5'd0, "match set up with no length")
  `LZSS_ASSERT_IMPLY(a_done_is_last, out_valid && out_done, out_last, "stream end off run end")
  `LZSS_ASSERT_NEXT(a_count_holds, out_valid && !out_link.ready && !cmd.clear,
                    $stable(count), "count moved while output stalled")
endmodule

[hw/rtl/lzss_ctrl.sv]
// Decoder controller: header, flag groups, token phase and match sequencing.
module lzss_ctrl (
  input  logic               clk,
  input  logic               rst,
  lzss_in_if.sink            in_link,
  input  lzss_pkg::dp_stat_t stat,
  output lzss_pkg::dp_cmd_t  cmd
);
  import lzss_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_COPY  = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [2:0] hdr, hdr_next;
  logic [7:0] flags, flags_next;
  logic [3:0] tokens, tokens_next;
  logic       finished, finished_next;
  logic       accept;
  logic       start;
  logic [7:0] b;

  assign in_link.ready = (state == ST_IDLE) && stat.e_empty;
  assign accept        = in_link.valid && in_link.ready;
  assign start         = in_link.stream_start;
  assign b             = in_link.in_byte;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    hdr_next      = hdr;
    flags_next    = flags;
    tokens_next   = tokens;
    finished_next = finished || stat.stream_end;
    cmd           = '0;
    cmd.data      = b;
    cmd.setup     = (state == ST_SETUP);
    cmd.copy_en   = (state == ST_COPY);

    unique case (state)
      ST_SETUP: state_next = ST_COPY;
      ST_COPY:  if (stat.copy_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase

    if (accept) begin
      if (start) begin
        cmd.clear   = 1'b1;
        cmd.hdr_we  = 1'b1;
        cmd.hdr_idx = 2'd0;
        hdr_next    = 3'd1;
        phase_next  = PH_FLAG;
        flags_next  = 8'd0;
        tokens_next = 4'd0;
        finished_next = 1'b0;
      end else if (!finished) begin
        if (hdr < HDR_BYTES) begin
          cmd.hdr_we  = 1'b1;
          cmd.hdr_idx = hdr[1:0];
          hdr_next    = hdr + 3'd1;
          if ((hdr == HDR_LAST) && stat.len_low_zero && (b == 8'd0)) begin
            finished_next = 1'b1;
          end
        end else begin
          unique case (phase)
            PH_TOKEN: begin
              if (flags[0]) begin
                cmd.lit_load = 1'b1;
                cmd.grp_end  = (tokens == 4'd1);
                flags_next   = flags >> 1;
                tokens_next  = tokens - 4'd1;
                if (tokens == 4'd1) phase_next = PH_FLAG;
              end else begin
                cmd.off_load = 1'b1;
                phase_next   = PH_MATCH;
              end
            end
            PH_MATCH: begin
              cmd.match_load = 1'b1;
              cmd.grp_end    = (tokens == 4'd1);
              flags_next     = flags >> 1;
              tokens_next    = tokens - 4'd1;
              phase_next     = (tokens == 4'd1) ? PH_FLAG : PH_TOKEN;
              state_next     = ST_SETUP;
            end
            default: begin
              flags_next  = b;
              tokens_next = FLAG_TOKENS;
              phase_next  = PH_TOKEN;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_FLAG;
      hdr      <= 3'd0;
      flags    <= 8'd0;
      tokens   <= 4'd0;
      finished <= 1'b1;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      hdr      <= hdr_next;
      flags    <= flags_next;
      tokens   <= tokens_next;
      finished <= finished_next;
    end
  end
endmodule
